>>> design/cdvw_pkg.sv
// Package for the valid-window 2D convolution core: shared types, field widths,
// register indexes and command codes. No dependencies.
`timescale 1ns / 1ps

package cdvw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 40;
  localparam int ROW_W    = 16;
  localparam int OCOL_W   = 10;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FLIP_KERNEL  = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;
  localparam logic               FLIP_KERNEL_RST  = 1'b1;

  // Request kinds carried in in_tuser.
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Controls shared by every window cell.
  typedef struct packed {
    logic shift;
    logic flip;
  } cell_ctl_t;

  // Position and frame marker that travel beside a sum.
  typedef struct packed {
    logic              last;
    logic [OCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
  } meta_t;

endpackage

>>> design/cdvw_line.sv
// One line buffer row of the convolution core: a memory of one image row with
// a registered read port and write-to-read forwarding. Uses cdvw_pkg.
`timescale 1ns / 1ps

module cdvw_line #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  cdvw_pkg::sample_t wdata,
  input  logic [AW-1:0]     raddr,
  output cdvw_pkg::sample_t rdata
);

  cdvw_pkg::sample_t mem [DEPTH];
  cdvw_pkg::sample_t rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // A write to the address being fetched returns the new data.
    if (we && (waddr == raddr)) begin
      rd_r <= wdata;
    end else begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

>>> design/cdvw_cell.sv
// One window cell of the convolution core: holds one window sample, passes it
// to its left neighbor on every shift and forms its registered tap product. Uses cdvw_pkg.
`timescale 1ns / 1ps

module cdvw_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  cdvw_pkg::cell_ctl_t ctl,
  input  cdvw_pkg::sample_t   shift_in,
  input  cdvw_pkg::weight_t   weight_fwd,
  input  cdvw_pkg::weight_t   weight_flip,
  output cdvw_pkg::sample_t   win_out,
  output cdvw_pkg::prod_t     prod_out
);

  cdvw_pkg::sample_t win_r;
  cdvw_pkg::prod_t   prod_r;
  cdvw_pkg::weight_t wsel;

  assign wsel = ctl.flip ? weight_flip : weight_fwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= cdvw_pkg::prod_t'(win_r) * cdvw_pkg::prod_t'(wsel);
  end

  assign win_out  = win_r;
  assign prod_out = prod_r;

endmodule

>>> design/cdvw_sum.sv
// Registered pairwise adder tree that sums the tap products of the window
// cells into one full-precision result. Uses cdvw_pkg.
`timescale 1ns / 1ps

module cdvw_sum #(
  parameter int N = 9
) (
  input  logic              clk,
  input  cdvw_pkg::prod_t   leaf [N],
  output cdvw_pkg::sum_t    root
);

  localparam int LV = (N > 1) ? $clog2(N) : 0;
  localparam int P  = 1 << LV;

  cdvw_pkg::sum_t leaf_ext [P];

  genvar i;
  generate
    for (i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_used
        assign leaf_ext[i] = cdvw_pkg::sum_t'(leaf[i]);
      end else begin : g_pad
        assign leaf_ext[i] = '0;
      end
    end

    if (LV == 0) begin : g_single
      assign root = leaf_ext[0];
    end else begin : g_tree
      // Heap order: node j adds nodes 2j and 2j+1; indexes at or past P are leaves.
      cdvw_pkg::sum_t node_r [1:P-1];

      always_ff @(posedge clk) begin
        for (int j = 1; j < P; j++) begin
          if (2 * j >= P) begin
            node_r[j] <= leaf_ext[2*j-P] + leaf_ext[2*j+1-P];
          end else begin
            node_r[j] <= node_r[2*j] + node_r[2*j+1];
          end
        end
      end

      assign root = node_r[1];
    end
  endgenerate

endmodule

>>> design/conv2d_valid_window_core.sv
// Valid-region 2D convolution core. An image sample that completes a window is offered on
// out_tvalid once it has passed the window cells, the product registers and the adder tree
// and been written into the output queue. Throughput: one request per cycle, weights or samples,
// limited only by the output queue, whose credits hold back in_tready when full.
// Reset (synchronous, rst_n low) clears counters, window, valid flags and queue pointers, and loads
// width 1024, height 1024 and flipped-kernel mode; kernel and line memories keep no reset.
`timescale 1ns / 1ps

module conv2d_valid_window_core #(
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] weight_index, [19:4] weight_value, [35:20] sample, [39:36] zero.
  input  logic [39:0] in_tdata,
  // [0] command: weight load or image sample.
  input  logic        in_tuser,

  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [39:0] conv_value, [55:40] out_row, [65:56] out_col, [71:66] zero.
  output logic [71:0] out_tdata,
  output logic        out_tlast,

  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Sizes that follow from the kernel and line length.
  localparam int NTAP = KERNEL_ROWS * KERNEL_COLS;
  localparam int LV   = (NTAP > 1) ? $clog2(NTAP) : 0;   // adder tree depth
  localparam int NST  = LV + 2;                          // window, products, tree
  localparam int FAW  = $clog2(LV + 4);                  // output queue address bits
  localparam int FD   = 1 << FAW;                        // output queue depth
  localparam int CW   = $clog2(MAX_WIDTH);               // column counter bits
  localparam int EW   = (($clog2(MAX_WIDTH + 1) > cdvw_pkg::IMG_W_W) ?
                         $clog2(MAX_WIDTH + 1) : cdvw_pkg::IMG_W_W) + 1;
  localparam int HW   = cdvw_pkg::IMG_H_W + 1;
  localparam int KAW  = (NTAP > 1) ? $clog2(NTAP) : 1;
  localparam int IW   = ((KAW > 4) ? KAW : 4) + 1;
  localparam int LR   = (KERNEL_ROWS > 1) ? KERNEL_ROWS - 1 : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands on the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  logic [cdvw_pkg::IMG_W_W-1:0] img_w_r;
  logic [cdvw_pkg::IMG_H_W-1:0] img_h_r;
  logic                         flip_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= cdvw_pkg::IMAGE_WIDTH_RST;
      img_h_r <= cdvw_pkg::IMAGE_HEIGHT_RST;
      flip_r  <= cdvw_pkg::FLIP_KERNEL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cdvw_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_pwdata[cdvw_pkg::IMG_W_W-1:0];
        cdvw_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_pwdata[cdvw_pkg::IMG_H_W-1:0];
        cdvw_pkg::REG_FLIP_KERNEL:  flip_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cdvw_pkg::REG_IMAGE_WIDTH:  cfg_prdata = cdvw_pkg::CFG_DW'(img_w_r);
      cdvw_pkg::REG_IMAGE_HEIGHT: cfg_prdata = cdvw_pkg::CFG_DW'(img_h_r);
      cdvw_pkg::REG_FLIP_KERNEL:  cfg_prdata = cdvw_pkg::CFG_DW'(flip_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input request decode and acceptance. The output queue hands out credits:
  // every sample that will produce a result reserves one slot when it is taken,
  // so results never need to stall the pipeline.
  // ---------------------------------------------------------------------------
  logic              in_cmd;
  logic [3:0]        in_widx;
  cdvw_pkg::weight_t in_wval;
  cdvw_pkg::sample_t in_smp;
  logic              in_acc;
  logic              smp_acc;
  logic              wgt_acc;
  logic [FAW:0]      credit_r;
  logic [FAW:0]      credit_nxt;

  assign in_cmd  = in_tuser;
  assign in_widx = in_tdata[3:0];
  assign in_wval = in_tdata[19:4];
  assign in_smp  = in_tdata[35:20];

  assign in_tready = (credit_r != (FAW + 1)'(FD));
  assign in_acc    = in_tvalid & in_tready;
  assign smp_acc   = in_acc & (in_cmd == cdvw_pkg::CMD_SAMPLE);
  assign wgt_acc   = in_acc & (in_cmd == cdvw_pkg::CMD_WEIGHT);

  // ---------------------------------------------------------------------------
  // Kernel store. Each entry sits at a fixed place, so it lives in flip-flops.
  // Loads past the kernel size are dropped. A load only affects samples taken
  // after it, because the products are registered on the following edge.
  // ---------------------------------------------------------------------------
  cdvw_pkg::weight_t kern_r [NTAP];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NTAP; i++) begin
      if (wgt_acc && (IW'(in_widx) == IW'(i))) begin
        kern_r[i] <= in_wval;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position. The counters wrap as soon as they reach the last column or
  // row, so shrinking the image between frames never lets them run past it.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]                col_r;
  logic [CW-1:0]                col_nxt;
  logic [cdvw_pkg::ROW_W-1:0]   row_r;
  logic [cdvw_pkg::ROW_W-1:0]   row_nxt;
  logic [EW-1:0]                img_w_ext;
  logic [EW-1:0]                w_eff;
  logic [HW-1:0]                h_eff;
  logic [EW-1:0]                col_p1;
  logic [HW-1:0]                row_p1;
  logic                         row_end;
  logic                         frame_end;
  logic                         emit;

  assign img_w_ext = EW'(img_w_r);

  always_comb begin
    if (img_w_ext < EW'(KERNEL_COLS)) begin
      w_eff = EW'(KERNEL_COLS);
    end else if (img_w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = img_w_ext;
    end
  end

  assign h_eff = (HW'(img_h_r) < HW'(KERNEL_ROWS)) ? HW'(KERNEL_ROWS) : HW'(img_h_r);

  assign col_p1    = EW'(col_r) + EW'(1);
  assign row_p1    = HW'(row_r) + HW'(1);
  assign row_end   = (col_p1 >= w_eff);
  assign frame_end = row_end && (row_p1 >= h_eff);
  assign emit      = (row_r >= cdvw_pkg::ROW_W'(KERNEL_ROWS - 1)) &&
                     (col_r >= CW'(KERNEL_COLS - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (smp_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_p1[cdvw_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers. Row 0 holds the oldest line. Each memory prefetches the entry
  // for the column of the next sample, so its data is ready in a register when
  // that sample arrives; on a sample, every row takes the entry of the row below.
  // ---------------------------------------------------------------------------
  cdvw_pkg::sample_t line_rd [LR];

  genvar r, c;
  generate
    for (r = 0; r < KERNEL_ROWS - 1; r++) begin : g_line
      cdvw_pkg::sample_t line_wd;

      if (r < KERNEL_ROWS - 2) begin : g_mid
        assign line_wd = line_rd[r+1];
      end else begin : g_top
        assign line_wd = in_smp;
      end

      cdvw_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
      ) u_line (
        .clk   (clk),
        .we    (smp_acc),
        .waddr (col_r),
        .wdata (line_wd),
        .raddr (col_nxt),
        .rdata (line_rd[r])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Window: a row of cells per kernel row. On every sample each cell takes the
  // value of its right neighbor; the rightmost cell of a row takes the line
  // buffer output, or the new sample in the bottom row. Each cell multiplies its
  // sample by its kernel weight, picked for convolution or correlation.
  // ---------------------------------------------------------------------------
  cdvw_pkg::cell_ctl_t cell_ctl;
  cdvw_pkg::sample_t   win   [NTAP];
  cdvw_pkg::prod_t     prod  [NTAP];
  cdvw_pkg::sum_t      sum_root;

  assign cell_ctl.shift = smp_acc;
  assign cell_ctl.flip  = flip_r;

  generate
    for (r = 0; r < KERNEL_ROWS; r++) begin : g_row
      for (c = 0; c < KERNEL_COLS; c++) begin : g_col
        cdvw_pkg::sample_t shift_in;

        if (c < KERNEL_COLS - 1) begin : g_inner
          assign shift_in = win[r*KERNEL_COLS+c+1];
        end else if (r < KERNEL_ROWS - 1) begin : g_from_line
          assign shift_in = line_rd[r];
        end else begin : g_from_input
          assign shift_in = in_smp;
        end

        cdvw_cell u_cell (
          .clk         (clk),
          .rst_n       (rst_n),
          .ctl         (cell_ctl),
          .shift_in    (shift_in),
          .weight_fwd  (kern_r[r*KERNEL_COLS+c]),
          .weight_flip (kern_r[(KERNEL_ROWS-1-r)*KERNEL_COLS+(KERNEL_COLS-1-c)]),
          .win_out     (win[r*KERNEL_COLS+c]),
          .prod_out    (prod[r*KERNEL_COLS+c])
        );
      end
    end
  endgenerate

  cdvw_sum #(
    .N (NTAP)
  ) u_sum (
    .clk  (clk),
    .leaf (prod),
    .root (sum_root)
  );

  // ---------------------------------------------------------------------------
  // Position and frame marker travel beside the arithmetic, one stage per edge,
  // so they meet the sum at the tree root.
  // ---------------------------------------------------------------------------
  logic            vld_r  [NST];
  cdvw_pkg::meta_t meta_r [NST];
  cdvw_pkg::meta_t meta_in;

  assign meta_in.row  = row_r - cdvw_pkg::ROW_W'(KERNEL_ROWS - 1);
  assign meta_in.col  = cdvw_pkg::OCOL_W'(col_r - CW'(KERNEL_COLS - 1));
  assign meta_in.last = frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= smp_acc & emit;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_in;
    for (int s = 1; s < NST; s++) begin
      meta_r[s] <= meta_r[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue. Finished results wait here, so the pipeline keeps moving while
  // the consumer stalls; in_tready drops only when every slot is spoken for.
  // ---------------------------------------------------------------------------
  cdvw_pkg::sum_t  q_sum_r  [FD];
  cdvw_pkg::meta_t q_meta_r [FD];
  logic [FAW:0]    wptr_r;
  logic [FAW:0]    rptr_r;
  logic            q_push;
  logic            q_pop;
  logic            credit_inc;

  assign q_push     = vld_r[NST-1];
  assign q_pop      = out_tvalid & out_tready;
  assign credit_inc = smp_acc & emit;

  always_comb begin
    credit_nxt = credit_r;
    if (credit_inc && !q_pop) begin
      credit_nxt = credit_r + (FAW + 1)'(1);
    end else if (!credit_inc && q_pop) begin
      credit_nxt = credit_r - (FAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      wptr_r   <= '0;
      rptr_r   <= '0;
    end else begin
      credit_r <= credit_nxt;
      if (q_push) begin
        wptr_r <= wptr_r + (FAW + 1)'(1);
      end
      if (q_pop) begin
        rptr_r <= rptr_r + (FAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_sum_r[wptr_r[FAW-1:0]]  <= sum_root;
      q_meta_r[wptr_r[FAW-1:0]] <= meta_r[NST-1];
    end
  end

  cdvw_pkg::meta_t q_meta_out;

  assign q_meta_out = q_meta_r[rptr_r[FAW-1:0]];
  assign out_tvalid = (wptr_r != rptr_r);
  assign out_tdata  = {6'b0, q_meta_out.col, q_meta_out.row, q_sum_r[rptr_r[FAW-1:0]]};
  assign out_tlast  = q_meta_out.last;

endmodule
